@@ hdl/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package psc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CAL0 = 2'd0,
    REG_CAL1 = 2'd1,
    REG_CAL2 = 2'd2,
    REG_OSS  = 2'd3
  } psc_reg_t;

  // compensation constants
  localparam int                 TEMP_OFFSET = 4000;
  localparam int                 PRESS_SCALE = 50000;
  localparam logic [31:0]        B7_SPLIT    = 32'h8000_0000;
  localparam int                 B4_BIAS     = 32768;
  localparam logic [11:0]        PC1         = 12'd3038;
  localparam logic signed [14:0] PC2         = -15'sd7357;
  localparam int                 PC3         = 3791;

  // divided pressure at or above this ends in positive saturation (faulted items apart)
  localparam int                 P_CLAMP     = 1 << 21;

endpackage

@@ hdl/psc_in_if.sv @@
// ----------------------------------------------------------------------------
// psc_in_if
// Input item channel: one raw temperature and one raw pressure reading.
// ----------------------------------------------------------------------------
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

@@ hdl/psc_out_if.sv @@
// ----------------------------------------------------------------------------
// psc_out_if
// Result item channel: compensated temperature, pressure and fault flag.
// ----------------------------------------------------------------------------
interface psc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic        [19:0] pressure;
  logic               fault;

  modport source (output valid, output temperature, output pressure, output fault,
                  input ready);
  modport sink   (input valid, input temperature, input pressure, input fault,
                  output ready);
endinterface

@@ hdl/psc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// psc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface psc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/psc_div.sv @@
// ----------------------------------------------------------------------------
// psc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word that travels along. The whole pipe moves when en is high.
// ----------------------------------------------------------------------------
module psc_div #(
  parameter int NW = 27,
  parameter int DW = 19,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          v_r    [NW];
  logic [NW-1:0] num_r  [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];
  logic [DW+NW-1:0] step_nxt [NW];

  // one restoring step: remainder and numerator/quotient shift word
  function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [NW-1:0] num,
                                                input logic [DW-1:0] den);
    logic [DW:0] t;
    logic [DW:0] d;
    logic        ge;
    t  = {rem, num[NW-1]};
    d  = t - {1'b0, den};
    ge = (t >= {1'b0, den});
    return {(ge ? d[DW-1:0] : t[DW-1:0]), num[NW-2:0], ge};
  endfunction

  always_comb begin
    step_nxt[0] = div_step('0, in_num, in_den);
    for (int s = 1; s < NW; s++) begin
      step_nxt[s] = div_step(rem_r[s-1], num_r[s-1], den_r[s-1]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NW; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < NW; s++) v_r[s] <= v_r[s-1];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= step_nxt[0][DW+NW-1:NW];
      num_r[0]  <= step_nxt[0][NW-1:0];
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int s = 1; s < NW; s++) begin
        rem_r[s]  <= step_nxt[s][DW+NW-1:NW];
        num_r[s]  <= step_nxt[s][NW-1:0];
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = num_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

@@ hdl/pressure_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch  writes the calibration words (index 0..2) and the oversampling
//           setting (index 3); always ready, write only while idle.
//   in_ch   takes one item (raw temperature, raw pressure) per cycle while in_ch.ready is high.
//   out_ch  gives one item per input: temperature in 0.1 C, pressure in Pa,
//           fault when a divisor was zero (then both values are zero).
// Throughput: one item per cycle unless stalled. Path from acceptance to out_ch.valid:
//   the two bit-serial divider pipes (27 and 33 stages), 17 arithmetic stages
//   and the output register.
// Reset: clears the configuration registers to zero and empties the pipe.
// Stall: the output register plus a one-item skid buffer hold results; once
//   the skid is occupied the whole pipe freezes and in_ch.ready drops until
//   out_ch takes an item. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
  input  logic   clk,
  input  logic   rst_n,
  psc_cfg_if.sink  cfg_ch,
  psc_in_if.sink   in_ch,
  psc_out_if.source out_ch
);
  import psc_pkg::*;

  // configuration registers (MB field of word 2 is never used, not stored)
  logic [63:0] cal0_r, cal1_r;
  logic [31:0] cal2_r;
  logic [1:0]  oss_r;

  logic signed [15:0] ac1, ac2, ac3, b1, b2;
  logic        [15:0] ac4, ac5, ac6, mc, md;

  logic adv;

  // pipe registers
  logic s1_v_r, s2_v_r, s3_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r, s10_v_r;
  logic s11_v_r, s12_v_r, s13_v_r, s14_v_r, s16_v_r, s17_v_r, s18_v_r, s19_v_r;

  logic [16:0] s1_dt_r;   logic [18:0] s1_up_r;
  logic [33:0] s2_prod_r; logic [18:0] s2_up_r;
  logic [18:0] s3_x1_r;   logic [19:0] s3_d1_r; logic [18:0] s3_up_r;

  logic        d1_valid;  logic [26:0] d1_quo; logic [39:0] d1_side;
  logic [15:0] mc_mag;    logic [19:0] d1_mag; logic [27:0] x2_nxt;

  logic [28:0] s5_b5_r;   logic [18:0] s5_up_r; logic s5_f_r;
  logic [29:0] tr_nxt;    logic [25:0] ts_nxt;  logic [15:0] t_nxt;
  logic [29:0] s6_b6_r;   logic [15:0] s6_t_r;  logic [18:0] s6_up_r; logic s6_f_r;
  logic [29:0] mag_nxt;
  logic [29:0] s7_hh_r, s7_hl_r, s7_ll_r;
  logic signed [45:0] pa2_nxt, pa3_nxt;
  logic [45:0] s7_pa2_r, s7_pa3_r;
  logic [15:0] s7_t_r;    logic [18:0] s7_up_r; logic s7_f_r;
  logic [59:0] sq_nxt;
  logic [47:0] s8_s_r;    logic [45:0] s8_pa2_r, s8_pa3_r;
  logic [15:0] s8_t_r;    logic [18:0] s8_up_r; logic s8_f_r;
  logic signed [40:0] pb2h_nxt, pb2l_nxt, pb1h_nxt, pb1l_nxt;
  logic [40:0] s9_pb2h_r, s9_pb2l_r, s9_pb1h_r, s9_pb1l_r;
  logic [45:0] s9_pa2_r, s9_pa3_r;
  logic [15:0] s9_t_r;    logic [18:0] s9_up_r; logic s9_f_r;
  logic [49:0] s10_p2_r, s10_p1_r;
  logic [45:0] s10_pa2_r, s10_pa3_r;
  logic [15:0] s10_t_r;   logic [18:0] s10_up_r; logic s10_f_r;
  logic [33:0] s11_x3_r, s11_sum2_r;
  logic [15:0] s11_t_r;   logic [18:0] s11_up_r; logic s11_f_r;
  logic [33:0] inner_nxt, sh_nxt, v_nxt;
  logic [31:0] s12_b3_r, s12_xb_r;
  logic [15:0] s12_t_r;   logic [18:0] s12_up_r; logic s12_f_r;
  logic [47:0] b4p_nxt;
  logic [16:0] s13_b4_r;  logic [31:0] s13_diff_r;
  logic [15:0] s13_t_r;   logic s13_f_r;
  logic [15:0] scale_nxt; logic [47:0] b7_nxt;
  logic [31:0] s14_b7_r;  logic [16:0] s14_b4_r;
  logic [15:0] s14_t_r;   logic s14_f_r;

  logic        dbl_nxt;   logic [32:0] num2_nxt;
  logic        d2_valid;  logic [32:0] d2_quo; logic [17:0] d2_side;
  logic [33:0] pu_nxt;

  logic [21:0] s16_p_r;   logic [15:0] s16_t_r; logic s16_f_r;
  logic signed [37:0] x2m_nxt;
  logic [27:0] s17_q8sq_r; logic [37:0] s17_x2m_r;
  logic [21:0] s17_p_r;   logic [15:0] s17_t_r; logic s17_f_r;
  logic [39:0] s18_x1m_r; logic [21:0] s18_x2_r;
  logic [21:0] s18_p_r;   logic [15:0] s18_t_r; logic s18_f_r;
  logic [25:0] sum3_nxt;
  logic [26:0] s19_pf_r;  logic [15:0] s19_t_r; logic s19_f_r;

  logic [19:0] press_nxt;
  logic        out_v_r, skid_v_r;
  logic [15:0] out_temp_r, skid_temp_r;
  logic [19:0] out_press_r, skid_press_r;
  logic        out_fault_r, skid_fault_r;
  logic        take;

  // --------------------------------------------------------------------------
  // configuration port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal0_r <= '0;
      cal1_r <= '0;
      cal2_r <= '0;
      oss_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CAL0: cal0_r <= cfg_ch.data;
        REG_CAL1: cal1_r <= cfg_ch.data;
        REG_CAL2: cal2_r <= cfg_ch.data[31:0];
        REG_OSS:  oss_r  <= cfg_ch.data[1:0];
        default:  ;
      endcase
    end
  end

  // coefficient fields
  assign ac1 = cal0_r[63:48];
  assign ac2 = cal0_r[47:32];
  assign ac3 = cal0_r[31:16];
  assign ac4 = cal0_r[15:0];
  assign ac5 = cal1_r[63:48];
  assign ac6 = cal1_r[47:32];
  assign b1  = cal1_r[31:16];
  assign b2  = cal1_r[15:0];
  assign mc  = cal2_r[31:16];
  assign md  = cal2_r[15:0];

  // whole pipe moves unless the skid buffer holds an item
  assign adv         = !skid_v_r;
  assign in_ch.ready = adv;

  // --------------------------------------------------------------------------
  // valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {s1_v_r, s2_v_r, s3_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r} <= '0;
      {s10_v_r, s11_v_r, s12_v_r, s13_v_r, s14_v_r} <= '0;
      {s16_v_r, s17_v_r, s18_v_r, s19_v_r} <= '0;
    end else if (adv) begin
      s1_v_r  <= in_ch.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s5_v_r  <= d1_valid;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
      s12_v_r <= s11_v_r;
      s13_v_r <= s12_v_r;
      s14_v_r <= s13_v_r;
      s16_v_r <= d2_valid;
      s17_v_r <= s16_v_r;
      s18_v_r <= s17_v_r;
      s19_v_r <= s18_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // temperature front end: X1 and the first divisor
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dt_r   <= {1'b0, in_ch.raw_temperature} - {1'b0, ac6};
      s1_up_r   <= in_ch.raw_pressure;
      s2_prod_r <= $signed(s1_dt_r) * $signed({1'b0, ac5});
      s2_up_r   <= s1_up_r;
      s3_x1_r   <= s2_prod_r[33:15];
      s3_d1_r   <= {s2_prod_r[33], s2_prod_r[33:15]} + {{4{md[15]}}, md};
      s3_up_r   <= s2_up_r;
    end
  end

  // MC*2048 / (X1+MD) as magnitudes, sign applied afterwards
  assign mc_mag = mc[15] ? (16'd0 - mc) : mc;
  assign d1_mag = s3_d1_r[19] ? (20'd0 - s3_d1_r) : s3_d1_r;

  psc_div #(.NW(27), .DW(19), .SW(40)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s3_v_r),
    .in_num   ({mc_mag, 11'd0}),
    .in_den   (d1_mag[18:0]),
    .in_side  ({s3_x1_r, s3_up_r, (s3_d1_r == 20'd0), (mc[15] ^ s3_d1_r[19])}),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // --------------------------------------------------------------------------
  // B5, T, B6 and the B6 products
  always_comb begin
    x2_nxt  = d1_side[0] ? (28'd0 - {1'b0, d1_quo}) : {1'b0, d1_quo};
    tr_nxt  = {s5_b5_r[28], s5_b5_r} + 30'd8;
    ts_nxt  = tr_nxt[29:4];
    if (!ts_nxt[25] && (ts_nxt[24:15] != 10'd0))      t_nxt = 16'h7FFF;
    else if (ts_nxt[25] && (ts_nxt[24:15] != 10'h3FF)) t_nxt = 16'h8000;
    else                                               t_nxt = ts_nxt[15:0];
    mag_nxt = s6_b6_r[29] ? (30'd0 - s6_b6_r) : s6_b6_r;
    pa2_nxt = ac2 * $signed(s6_b6_r);
    pa3_nxt = ac3 * $signed(s6_b6_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_b5_r  <= {{10{d1_side[39]}}, d1_side[39:21]} + {x2_nxt[27], x2_nxt};
      s5_up_r  <= d1_side[20:2];
      s5_f_r   <= d1_side[1];
      s6_b6_r  <= {s5_b5_r[28], s5_b5_r} - 30'(TEMP_OFFSET);
      s6_t_r   <= t_nxt;
      s6_up_r  <= s5_up_r;
      s6_f_r   <= s5_f_r;
      // B6 squared from three 15-bit partial products
      s7_hh_r  <= {15'd0, mag_nxt[29:15]} * {15'd0, mag_nxt[29:15]};
      s7_hl_r  <= {15'd0, mag_nxt[29:15]} * {15'd0, mag_nxt[14:0]};
      s7_ll_r  <= {15'd0, mag_nxt[14:0]} * {15'd0, mag_nxt[14:0]};
      s7_pa2_r <= pa2_nxt;
      s7_pa3_r <= pa3_nxt;
      s7_t_r   <= s6_t_r;
      s7_up_r  <= s6_up_r;
      s7_f_r   <= s6_f_r;
    end
  end

  // --------------------------------------------------------------------------
  // (B6*B6)>>12 and its products with B2 and B1
  always_comb begin
    sq_nxt   = {s7_hh_r, 30'd0} + {14'd0, s7_hl_r, 16'd0} + {30'd0, s7_ll_r};
    pb2h_nxt = b2 * $signed({1'b0, s8_s_r[47:24]});
    pb2l_nxt = b2 * $signed({1'b0, s8_s_r[23:0]});
    pb1h_nxt = b1 * $signed({1'b0, s8_s_r[47:24]});
    pb1l_nxt = b1 * $signed({1'b0, s8_s_r[23:0]});
  end

  // everything after this point only matters modulo 2^32, so low bits suffice
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_s_r    <= sq_nxt[59:12];
      s8_pa2_r  <= s7_pa2_r;
      s8_pa3_r  <= s7_pa3_r;
      s8_t_r    <= s7_t_r;
      s8_up_r   <= s7_up_r;
      s8_f_r    <= s7_f_r;
      s9_pb2h_r <= pb2h_nxt;
      s9_pb2l_r <= pb2l_nxt;
      s9_pb1h_r <= pb1h_nxt;
      s9_pb1l_r <= pb1l_nxt;
      s9_pa2_r  <= s8_pa2_r;
      s9_pa3_r  <= s8_pa3_r;
      s9_t_r    <= s8_t_r;
      s9_up_r   <= s8_up_r;
      s9_f_r    <= s8_f_r;
      s10_p2_r  <= {s9_pb2h_r[25:0], 24'd0} + {{9{s9_pb2l_r[40]}}, s9_pb2l_r};
      s10_p1_r  <= {s9_pb1h_r[25:0], 24'd0} + {{9{s9_pb1l_r[40]}}, s9_pb1l_r};
      s10_pa2_r <= s9_pa2_r;
      s10_pa3_r <= s9_pa3_r;
      s10_t_r   <= s9_t_r;
      s10_up_r  <= s9_up_r;
      s10_f_r   <= s9_f_r;
      // X3 for B3, and X1+X2+2 for the B4 path
      s11_x3_r   <= s10_p2_r[44:11] + s10_pa2_r[44:11];
      s11_sum2_r <= {s10_pa3_r[45], s10_pa3_r[45:13]} + s10_p1_r[49:16] + 34'd2;
      s11_t_r    <= s10_t_r;
      s11_up_r   <= s10_up_r;
      s11_f_r    <= s10_f_r;
    end
  end

  // --------------------------------------------------------------------------
  // B3, B4, B7
  always_comb begin
    inner_nxt = {{16{ac1[15]}}, ac1, 2'b00} + s11_x3_r;
    sh_nxt    = inner_nxt << oss_r;
    v_nxt     = sh_nxt + 34'd2;
    b4p_nxt   = {32'd0, ac4} * {16'd0, s12_xb_r};
    scale_nxt = 16'(PRESS_SCALE >> oss_r);
    b7_nxt    = {16'd0, s13_diff_r} * {32'd0, scale_nxt};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_b3_r   <= v_nxt[33:2];
      s12_xb_r   <= s11_sum2_r[33:2] + 32'(B4_BIAS);
      s12_t_r    <= s11_t_r;
      s12_up_r   <= s11_up_r;
      s12_f_r    <= s11_f_r;
      s13_b4_r   <= b4p_nxt[31:15];
      s13_diff_r <= {13'd0, s12_up_r} - s12_b3_r;
      s13_t_r    <= s12_t_r;
      s13_f_r    <= s12_f_r;
      s14_b7_r   <= b7_nxt[31:0];
      s14_b4_r   <= s13_b4_r;
      s14_t_r    <= s13_t_r;
      s14_f_r    <= s13_f_r | (s13_b4_r == 17'd0);
    end
  end

  // --------------------------------------------------------------------------
  // pressure division: (B7*2)/B4 below the split, (B7/B4)*2 above
  assign dbl_nxt  = (s14_b7_r < B7_SPLIT);
  assign num2_nxt = dbl_nxt ? {s14_b7_r, 1'b0} : {1'b0, s14_b7_r};

  psc_div #(.NW(33), .DW(17), .SW(18)) u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s14_v_r),
    .in_num   (num2_nxt),
    .in_den   (s14_b4_r),
    .in_side  ({s14_t_r, s14_f_r, dbl_nxt}),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // --------------------------------------------------------------------------
  // final pressure correction
  always_comb begin
    pu_nxt   = d2_side[0] ? {1'b0, d2_quo} : {d2_quo, 1'b0};
    x2m_nxt  = $signed({1'b0, s16_p_r}) * PC2;
    sum3_nxt = {2'b00, s18_x1m_r[39:16]} + {{4{s18_x2_r[21]}}, s18_x2_r} + 26'(PC3);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // a clamped value still saturates high at the end
      s16_p_r    <= (pu_nxt >= 34'(P_CLAMP)) ? 22'(P_CLAMP) : pu_nxt[21:0];
      s16_t_r    <= d2_side[17:2];
      s16_f_r    <= d2_side[1];
      s17_q8sq_r <= {14'd0, s16_p_r[21:8]} * {14'd0, s16_p_r[21:8]};
      s17_x2m_r  <= x2m_nxt;
      s17_p_r    <= s16_p_r;
      s17_t_r    <= s16_t_r;
      s17_f_r    <= s16_f_r;
      s18_x1m_r  <= {12'd0, s17_q8sq_r} * {28'd0, PC1};
      s18_x2_r   <= s17_x2m_r[37:16];
      s18_p_r    <= s17_p_r;
      s18_t_r    <= s17_t_r;
      s18_f_r    <= s17_f_r;
      s19_pf_r   <= {5'd0, s18_p_r} + {{5{sum3_nxt[25]}}, sum3_nxt[25:4]};
      s19_t_r    <= s18_t_r;
      s19_f_r    <= s18_f_r;
    end
  end

  // saturate pressure to 0..2^20-1
  always_comb begin
    if (s19_pf_r[26])                   press_nxt = 20'd0;
    else if (s19_pf_r[25:20] != 6'd0)   press_nxt = 20'hFFFFF;
    else                                press_nxt = s19_pf_r[19:0];
  end

  // --------------------------------------------------------------------------
  // output register and skid buffer
  assign take = out_v_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (s19_v_r) begin
      if (!out_v_r || take) out_v_r  <= 1'b1;
      else                  skid_v_r <= 1'b1;
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_temp_r  <= skid_temp_r;
        out_press_r <= skid_press_r;
        out_fault_r <= skid_fault_r;
      end
    end else if (s19_v_r) begin
      if (!out_v_r || take) begin
        out_temp_r  <= s19_f_r ? 16'd0 : s19_t_r;
        out_press_r <= s19_f_r ? 20'd0 : press_nxt;
        out_fault_r <= s19_f_r;
      end else begin
        skid_temp_r  <= s19_f_r ? 16'd0 : s19_t_r;
        skid_press_r <= s19_f_r ? 20'd0 : press_nxt;
        skid_fault_r <= s19_f_r;
      end
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.temperature = out_temp_r;
  assign out_ch.pressure    = out_press_r;
  assign out_ch.fault       = out_fault_r;

  // --------------------------------------------------------------------------
  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled without an output stall");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_fault_r) |-> (out_temp_r == 16'd0 && out_press_r == 20'd0))
    else $error("faulted item carries nonzero results");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(s19_v_r) && $stable(s19_pf_r))
    else $error("pipe moved while skid was full");

endmodule
